// ===== hw/rtl/srrv_pkg.sv =====
`timescale 1ns / 1ps
package srrv_pkg;
	localparam int TABLE_LEN = 24;
	localparam logic [63:0] GAIN_Q30 = 64'd652032875;

	typedef enum logic [2:0] {
		REG_SIZE_X   = 3'd0,
		REG_SIZE_Y   = 3'd1,
		REG_RADIUS   = 3'd2,
		REG_POINTS   = 3'd3,
		REG_MASK     = 3'd4
	} reg_idx_t;

	function automatic logic [31:0] atan_val(input int k);
		logic [31:0] t;
		begin
			unique case (k)
				0: t = 32'd536870912;  1: t = 32'd316933406;
				2: t = 32'd167458907;  3: t = 32'd85004756;
				4: t = 32'd42667331;   5: t = 32'd21354465;
				6: t = 32'd10679838;   7: t = 32'd5340245;
				8: t = 32'd2670163;    9: t = 32'd1335087;
				10: t = 32'd667544;    11: t = 32'd333772;
				12: t = 32'd166886;    13: t = 32'd83443;
				14: t = 32'd41722;     15: t = 32'd20861;
				16: t = 32'd10430;     17: t = 32'd5215;
				18: t = 32'd2608;      19: t = 32'd1304;
				20: t = 32'd652;       21: t = 32'd326;
				22: t = 32'd163;       23: t = 32'd81;
				default: t = 32'd0;
			endcase
			return t;
		end
	endfunction

	// corner selection result carried down the pipe
	typedef struct packed {
		logic       hit;
		logic       rounded;
		logic [1:0] corner;
		logic [8:0] count;
	} sel_t;
endpackage

// ===== hw/rtl/srrv_cordic.sv =====
`timescale 1ns / 1ps
module srrv_cordic import srrv_pkg::*; #(
	parameter int STAGES = 16,
	parameter int W = 36,
	parameter int TW = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic signed [W-1:0]  x_in,
	input  logic signed [33:0]   z_in,
	input  logic [TW-1:0]        tag_in,
	output logic                 out_valid,
	output logic signed [W-1:0]  x_out,
	output logic signed [W-1:0]  y_out,
	output logic [TW-1:0]        tag_out
);
	logic                vld_q [STAGES+1];
	logic signed [W-1:0] x_q [STAGES+1];
	logic signed [W-1:0] y_q [STAGES+1];
	logic signed [33:0]  z_q [STAGES+1];
	logic [TW-1:0]       tag_q [STAGES+1];

	always_comb begin
		vld_q[0] = in_valid;
		x_q[0] = x_in;
		y_q[0] = '0;
		z_q[0] = z_in;
		tag_q[0] = tag_in;
	end

	for (genvar k = 0; k < STAGES; k++) begin : g_stage
		logic signed [33:0] at;
		assign at = $signed({2'b00, atan_val(k)});
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k+1] <= 1'b0;
			end else if (en) begin
				vld_q[k+1] <= vld_q[k];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				tag_q[k+1] <= tag_q[k];
				if (!z_q[k][33]) begin
					x_q[k+1] <= x_q[k] - (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] + (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] - at;
				end else begin
					x_q[k+1] <= x_q[k] + (y_q[k] >>> k);
					y_q[k+1] <= y_q[k] - (x_q[k] >>> k);
					z_q[k+1] <= z_q[k] + at;
				end
			end
		end
	end

	assign out_valid = vld_q[STAGES];
	assign x_out = x_q[STAGES];
	assign y_out = y_q[STAGES];
	assign tag_out = tag_q[STAGES];
endmodule

// ===== hw/rtl/selective_rounded_rect_vertex_gen.sv =====
`timescale 1ns / 1ps
// channel   | valid        | stall        | payload
// in        | in_valid     | in_stall     | point_index
// out       | out_valid    | out_stall    | vertex_x, vertex_y, point_count, index_in_range
// cfg       | cfg_we       | -            | cfg_idx, cfg_data
// one transfer per cycle unless stalled; data passes s1, s2, s3, cordic, s4, output register
// the whole pipe advances when the output register is empty or taken
// in_stall is out_stall gated by an occupied output stage; nothing drops
// arst_n clears all valid bits and loads register reset values
module selective_rounded_rect_vertex_gen import srrv_pkg::*; #(
	parameter int MAX_CORNER_POINTS = 64,
	parameter int CORDIC_STAGES = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_idx,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         point_index,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [17:0] vertex_x,
	output logic signed [17:0] vertex_y,
	output logic [8:0]         point_count,
	output logic               index_in_range
);
	localparam int CW = 36;
	localparam int MW = $clog2(MAX_CORNER_POINTS + 1);
	localparam int RS = 30 + 2 * MW;   // reciprocal scale, 2^RS
	localparam int RW = RS + 1;
	localparam int RT = 1 << MW;
	localparam int PW = MW + RS + 1;

	logic [15:0] size_x_q, size_y_q;
	logic [14:0] radius_q;
	logic [6:0]  points_q;
	logic [3:0]  mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= 16'd1600;
			size_y_q <= 16'd1600;
			radius_q <= 15'd160;
			points_q <= 7'd8;
			mask_q <= 4'hf;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_SIZE_X: size_x_q <= cfg_data;
				REG_SIZE_Y: size_y_q <= cfg_data;
				REG_RADIUS: radius_q <= cfg_data[14:0];
				REG_POINTS: points_q <= cfg_data[6:0];
				REG_MASK:   mask_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// clamped point count per rounded corner
	logic [10:0] n_c;
	always_comb begin
		if (points_q == 7'd0) n_c = 11'd1;
		else if ({4'd0, points_q} > 11'(MAX_CORNER_POINTS)) n_c = 11'(MAX_CORNER_POINTS);
		else n_c = {4'd0, points_q};
	end

	// ceil(2^RS / (n-1)) per point count, a constant table
	// gives the exact floor of i*2^30/(n-1) for i < n
	logic [RW-1:0] recip_tab [RT];
	for (genvar g = 0; g < RT; g++) begin : g_recip
		if (g <= 1) begin : g_zero
			assign recip_tab[g] = '0;
		end else begin : g_val
			assign recip_tab[g] = RW'(((64'd1 << RS) + 64'(g) - 64'd2) / 64'(g - 1));
		end
	end

	logic adv;
	logic out_full_q;
	assign adv = !out_full_q || !out_stall;
	assign in_stall = !adv;

	// s1: corner search
	logic          v_s1;
	sel_t          sel_s1;
	logic [MW-1:0] lidx_s1;
	logic [MW-1:0] n_s1;
	sel_t          sel_c;
	logic [10:0]   lidx_c;
	always_comb begin
		logic [10:0] rem;
		logic [10:0] pts;
		logic [10:0] cnt;
		rem = {3'd0, point_index};
		cnt = '0;
		sel_c = '0;
		lidx_c = '0;
		for (int c = 0; c < 4; c++) begin
			pts = mask_q[c] ? n_c : 11'd1;
			if (!sel_c.hit && rem < pts) begin
				sel_c.hit = 1'b1;
				sel_c.rounded = mask_q[c];
				sel_c.corner = 2'(c);
				lidx_c = rem;
			end else if (!sel_c.hit) begin
				rem = rem - pts;
			end
			cnt = cnt + pts;
		end
		sel_c.count = (cnt > 11'd511) ? 9'd511 : cnt[8:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s1 <= sel_c;
			lidx_s1 <= lidx_c[MW-1:0];
			n_s1 <= n_c[MW-1:0];
		end
	end

	// s2: reciprocal lookup and multiply
	logic          v_s2;
	sel_t          sel_s2;
	logic [PW-1:0] prod_s2;
	logic [RW-1:0] rc;
	assign rc = recip_tab[n_s1];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s2 <= sel_s1;
			prod_s2 <= PW'(lidx_s1) * PW'(rc);
		end
	end

	// s3: phase and scaled radius
	logic               v_s3;
	sel_t               sel_s3;
	logic signed [33:0] z_s3;
	logic signed [CW-1:0] x0_s3;
	logic [45:0]        rk;
	assign rk = 46'(radius_q) * 46'(GAIN_Q30[30:0]);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s3 <= sel_s2;
			z_s3 <= $signed(34'(prod_s2 >> (RS - 30)));
			x0_s3 <= CW'(rk >> 14);
		end
	end

	logic               v_c;
	logic signed [CW-1:0] xc, yc;
	logic [$bits(sel_t)-1:0] tag_c;
	srrv_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .TW($bits(sel_t))) u_cordic (
		.clk, .arst_n, .en(adv), .in_valid(v_s3), .x_in(x0_s3), .z_in(z_s3),
		.tag_in(sel_s3), .out_valid(v_c), .x_out(xc), .y_out(yc), .tag_out(tag_c)
	);
	sel_t sel_c2;
	assign sel_c2 = sel_t'(tag_c);

	// s4: round cos/sin terms to signed Q20.0 integers
	logic               v_s4;
	sel_t               sel_s4;
	logic signed [19:0] c_s4, s_s4;
	logic signed [CW-1:0] xr, yr;
	assign xr = (xc + CW'(32768)) >>> 16;
	assign yr = (yc + CW'(32768)) >>> 16;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= v_c;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sel_s4 <= sel_c2;
			c_s4 <= 20'(xr);
			s_s4 <= 20'(yr);
		end
	end

	// s5: place on corner, saturate
	logic signed [19:0] r20, sx20, sy20, cx, cy, vx, vy;
	assign r20 = $signed({5'd0, radius_q});
	assign sx20 = $signed({4'd0, size_x_q});
	assign sy20 = $signed({4'd0, size_y_q});
	always_comb begin
		cx = (sel_s4.corner == 2'd1 || sel_s4.corner == 2'd2) ? sx20 - r20 : r20;
		cy = sel_s4.corner[1] ? sy20 - r20 : r20;
		vx = '0;
		vy = '0;
		if (!sel_s4.hit) begin
			vx = '0;
			vy = '0;
		end else if (!sel_s4.rounded) begin
			vx = (sel_s4.corner == 2'd1 || sel_s4.corner == 2'd2) ? sx20 : '0;
			vy = sel_s4.corner[1] ? sy20 : '0;
		end else begin
			unique case (sel_s4.corner)
				2'd0: begin vx = cx - c_s4; vy = cy - s_s4; end
				2'd1: begin vx = cx + s_s4; vy = cy - c_s4; end
				2'd2: begin vx = cx + c_s4; vy = cy + s_s4; end
				default: begin vx = cx - s_s4; vy = cy + c_s4; end
			endcase
		end
	end

	function automatic logic signed [17:0] sat18(input logic signed [19:0] v);
		if (v > 20'sd131071) return 18'sd131071;
		if (v < -20'sd131072) return -18'sd131072;
		return v[17:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_full_q <= 1'b0;
		else if (adv) out_full_q <= v_s4;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			vertex_x <= sat18(vx);
			vertex_y <= sat18(vy);
			point_count <= sel_s4.count;
			index_in_range <= sel_s4.hit;
		end
	end
	assign out_valid = out_full_q;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(vertex_x))
		else $error("output changed under stall");
	a_in_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without cause");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !index_in_range |-> vertex_x == 18'sd0 && vertex_y == 18'sd0)
		else $error("vertex not zero out of range");
endmodule

// ===== tb/selective_rounded_rect_vertex_gen_tb.sv =====
`timescale 1ns / 1ps
// rounded rectangle outline vertex generator: a directed table of corner cases,
// then random vertex requests under four flow-control phases, checked against
// literal answers or a behavioral vertex calculator running its own cordic
module selective_rounded_rect_vertex_gen_tb import srrv_pkg::*; ();
	localparam logic [2:0] REG_UNUSED = 3'd5;  // no such register, write is dropped
	localparam int CORDIC_STEPS = 16;
	localparam int PIPE_LATENCY = 20;          // drain wait margin, in cycles
	localparam int IDLE_LIMIT = 4000;          // cycles with no transfer at all
	localparam int HOLD_CYCLES = 120;          // long receiver hold-off
	localparam longint ARC_GAIN = 64'sd652032875;
	localparam longint ARC_STEP[CORDIC_STEPS] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861};

	typedef struct {
		logic signed [17:0] x;
		logic signed [17:0] y;
		logic [8:0]         cnt;
		logic               inr;
	} vertex_t;

	typedef struct packed {
		logic [15:0] sx;
		logic [15:0] sy;
		logic [14:0] rad;
		logic [6:0]  pts;
		logic [3:0]  mask;
	} shape_t;

	// one directed row: shape, requested index, optional literal answer
	typedef struct {
		shape_t      shp;
		logic [7:0]  idx;
		bit          literal;
		vertex_t     ans;
	} vec_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_idx = REG_SIZE_X;
	logic [15:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] point_index = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [17:0] vertex_x;
	logic signed [17:0] vertex_y;
	logic [8:0] point_count;
	logic index_in_range;

	shape_t shape;                 // what the block holds right now
	vertex_t pending_vertices[$];  // vertices still owed by the block
	int errors = 0;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	selective_rounded_rect_vertex_gen DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .point_index(point_index),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_x(vertex_x), .vertex_y(vertex_y),
		.point_count(point_count), .index_in_range(index_in_range)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// walk the corners, find the one holding the index, rotate on its arc
	function automatic vertex_t calc_vertex(shape_t s, logic [7:0] pidx);
		vertex_t v;
		longint n, idx, cnt, vx, vy, r, phi, cx, cy, x, y, z, dx, dy, c, sn, pts;
		bit hit, rnd;
		n = longint'(s.pts);
		if (n < 1) n = 1;
		if (n > 64) n = 64;
		idx = longint'(pidx);
		r = longint'(s.rad);
		cnt = 0;
		vx = 0;
		vy = 0;
		hit = 0;
		for (int cn = 0; cn < 4; cn++) begin
			rnd = s.mask[cn];
			pts = rnd ? n : 1;
			if (!hit && idx < pts) begin
				hit = 1;
				if (!rnd) begin
					vx = (cn == 1 || cn == 2) ? longint'(s.sx) : 0;
					vy = (cn >= 2) ? longint'(s.sy) : 0;
				end else begin
					// a one-point arc sits at the corner's start angle
					phi = (n > 1) ? (idx * 64'sd1073741824) / (n - 1) : 0;
					x = (r * ARC_GAIN) >>> 14;
					y = 0;
					z = phi;
					for (int k = 0; k < CORDIC_STEPS; k++) begin
						dx = y >>> k;
						dy = x >>> k;
						if (z >= 0) begin
							x -= dx; y += dy; z -= ARC_STEP[k];
						end else begin
							x += dx; y -= dy; z += ARC_STEP[k];
						end
					end
					c = (x + 32768) >>> 16;
					sn = (y + 32768) >>> 16;
					cx = (cn == 1 || cn == 2) ? longint'(s.sx) - r : r;
					cy = (cn >= 2) ? longint'(s.sy) - r : r;
					case (cn)
						0: begin vx = cx - c; vy = cy - sn; end
						1: begin vx = cx + sn; vy = cy - c; end
						2: begin vx = cx + c; vy = cy + sn; end
						default: begin vx = cx - sn; vy = cy + c; end
					endcase
				end
			end else if (!hit) begin
				idx -= pts;
			end
			cnt += pts;
		end
		if (vx > 131071) vx = 131071;
		if (vx < -131072) vx = -131072;
		if (vy > 131071) vy = 131071;
		if (vy < -131072) vy = -131072;
		if (cnt > 511) cnt = 511;
		v.x = vx[17:0];
		v.y = vy[17:0];
		v.cnt = cnt[8:0];
		v.inr = hit;
		return v;
	endfunction

	// back-to-back register writes, we stays high across them
	task automatic load_shape(shape_t s);
		logic [2:0] ri[6];
		logic [15:0] rd[6];
		ri = '{REG_SIZE_X, REG_SIZE_Y, REG_RADIUS, REG_POINTS, REG_MASK, REG_UNUSED};
		rd = '{s.sx, 16'(s.rad) | 16'h8000, 16'(s.rad), 16'(s.pts), 16'(s.mask), 16'hFFFF};
		rd[1] = s.sy;
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= ri[i];
			cfg_data <= rd[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		shape = s;
	endtask

	// sender holds off until every owed vertex is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_index(logic [7:0] idx, bit literal, vertex_t ans);
		if ($urandom_range(0, 99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		in_valid <= 1'b1;
		point_index <= idx;
		do @(posedge clk); while (in_stall);
		pending_vertices.push_back(literal ? ans : calc_vertex(shape, idx));
	endtask

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
		end
	end

	// result checker, one transfer at a time against the oldest owed vertex
	always @(posedge clk) begin
		vertex_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				errors++;
				$display("%0t: unexpected result x=%0d y=%0d", $time, vertex_x, vertex_y);
			end else begin
				e = pending_vertices.pop_front();
				if (vertex_x !== e.x) begin
					errors++;
					$display("%0t: vertex_x exp %0d got %0d", $time, e.x, vertex_x);
				end
				if (vertex_y !== e.y) begin
					errors++;
					$display("%0t: vertex_y exp %0d got %0d", $time, e.y, vertex_y);
				end
				if (point_count !== e.cnt) begin
					errors++;
					$display("%0t: point_count exp %0d got %0d", $time, e.cnt, point_count);
				end
				if (index_in_range !== e.inr) begin
					errors++;
					$display("%0t: index_in_range exp %0b got %0b", $time, e.inr,
						index_in_range);
				end
			end
		end
	end

	// watchdog: too long with no transfer on either channel
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles > IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		vec_row_t rows[$];
		shape_t dflt, sq, one, zero, big, hug, tiny, s;
		vertex_t none, v;
		logic [8:0] cnt;
		int hi;

		dflt = '{16'd1600, 16'd1600, 15'd160, 7'd8, 4'hF};
		sq = '{16'hFFFF, 16'd0, 15'd50, 7'd8, 4'h0};
		one = '{16'd1000, 16'd700, 15'd200, 7'd1, 4'hF};
		zero = '{16'd1000, 16'd700, 15'd200, 7'd0, 4'hA};
		big = '{16'hFFFF, 16'hFFFF, 15'h7FFF, 7'd127, 4'hF};
		hug = '{16'd0, 16'd0, 15'h7FFF, 7'd64, 4'h5};
		tiny = '{16'd3, 16'd3, 15'd0, 7'd2, 4'h6};
		none = '{18'sd0, 18'sd0, 9'd0, 1'b0};

		// reset values, arc ends, out of range right past the end
		rows.push_back('{dflt, 8'd255, 1, '{18'sd0, 18'sd0, 9'd32, 1'b0}});
		rows.push_back('{dflt, 8'd0, 0, none});
		rows.push_back('{dflt, 8'd7, 0, none});
		rows.push_back('{dflt, 8'd31, 0, none});
		rows.push_back('{dflt, 8'd32, 1, '{18'sd0, 18'sd0, 9'd32, 1'b0}});
		// all corners square: plain rectangle vertices
		rows.push_back('{sq, 8'd0, 1, '{18'sd0, 18'sd0, 9'd4, 1'b1}});
		rows.push_back('{sq, 8'd1, 1, '{18'sd65535, 18'sd0, 9'd4, 1'b1}});
		rows.push_back('{sq, 8'd2, 1, '{18'sd65535, 18'sd0, 9'd4, 1'b1}});
		rows.push_back('{sq, 8'd3, 1, '{18'sd0, 18'sd0, 9'd4, 1'b1}});
		rows.push_back('{sq, 8'd4, 1, '{18'sd0, 18'sd0, 9'd4, 1'b0}});
		// one-point arcs sit at the start angle
		rows.push_back('{one, 8'd0, 0, none});
		rows.push_back('{one, 8'd1, 0, none});
		rows.push_back('{one, 8'd2, 0, none});
		rows.push_back('{one, 8'd3, 0, none});
		// zero points behaves as one
		rows.push_back('{zero, 8'd3, 0, none});
		rows.push_back('{zero, 8'd4, 1, '{18'sd0, 18'sd0, 9'd4, 1'b0}});
		// points above the maximum clamp to it, largest everything
		rows.push_back('{big, 8'd0, 0, none});
		rows.push_back('{big, 8'd63, 0, none});
		rows.push_back('{big, 8'd200, 0, none});
		rows.push_back('{big, 8'd255, 0, none});
		// huge radius on a zero-size shape, mixed mask
		rows.push_back('{hug, 8'd30, 0, none});
		rows.push_back('{hug, 8'd129, 0, none});
		// zero radius, two-point arcs
		rows.push_back('{tiny, 8'd2, 0, none});
		rows.push_back('{tiny, 8'd5, 0, none});

		shape = dflt;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].shp != shape) begin
				drain();
				load_shape(rows[i].shp);
			end
			send_index(rows[i].idx, rows[i].literal, rows[i].ans);
		end

		// random part, four flow-control phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin snd_idle_pct = 0; rcv_stall_pct = 0; end
				1: begin snd_idle_pct = 49; rcv_stall_pct = 0; end
				2: begin snd_idle_pct = 0; rcv_stall_pct = 49; end
				default: begin snd_idle_pct = 27; rcv_stall_pct = 27; end
			endcase
			for (int blk = 0; blk < 4; blk++) begin
				drain();
				s.sx = 16'($urandom_range(0, 65535));
				s.sy = 16'($urandom_range(0, 65535));
				s.rad = ($urandom_range(0, 3) == 0) ? 15'($urandom_range(0, 32767))
					: 15'($urandom_range(0, 800));
				s.pts = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(1, 16));
				s.mask = 4'($urandom_range(0, 15));
				if (ph == 1 && blk == 0) s = '{16'd0, 16'd0, 15'd0, 7'd1, 4'h0};
				if (ph == 3 && blk == 0) s = '{16'hFFFF, 16'hFFFF, 15'h7FFF, 7'd64, 4'hF};
				load_shape(s);
				v = calc_vertex(shape, 8'd0);
				cnt = v.cnt;
				hi = (int'(cnt) + 2 > 255) ? 255 : int'(cnt) + 2;
				for (int it = 0; it < 52; it++) begin
					// long receiver hold-off while the sender keeps offering
					if (ph == 0 && blk == 1 && it == 5) hold_req++;
					if ($urandom_range(0, 99) < 85)
						send_index(8'($urandom_range(0, hi)), 0, none);
					else
						send_index(8'($urandom), 0, none);
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (PIPE_LATENCY + 10) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end
endmodule
